@@ rtl/maxi_pkg.sv @@
// Package for the peak interval overlap block.
// Holds the sizing constants, the port field widths and the sequencer state type.
// Used by the top level and the checker; depends on nothing.
package maxi_pkg;

    // Store depth and stored time width.
    localparam int MAX_INTERVALS = 256;
    localparam int TIME_BITS     = 16;

    // Index and count widths follow from the store depth.
    localparam int IDX_W = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
    localparam int CNT_W = $clog2(MAX_INTERVALS + 1);

    // Shared comparator width: covers times and room counts.
    localparam int CMP_W = (TIME_BITS > CNT_W) ? TIME_BITS : CNT_W;

    // Port field widths.
    localparam int TIME_IN_W    = 16;
    localparam int IN_TDATA_W   = 2 * TIME_IN_W;
    localparam int PEAK_W       = 9;
    localparam int OUT_TDATA_W  = 16;
    localparam int OUT_TUSER_W  = 2;
    localparam int PEAK_MAX     = 511;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BAD,
        ST_INS_CHK,
        ST_INS_CMP,
        ST_SW_INIT,
        ST_SW_RD,
        ST_SW_CMP,
        ST_SW_DONE
    } t_state;

endpackage

@@ rtl/max_interval_overlap.sv @@
// Peak interval overlap (minimum meeting rooms). Each input word carries one interval
// (start in tdata[15:0], end in tdata[31:16]); tlast closes the set. Every accepted word
// is inserted in sorted place into a start store and an end store, shifting each larger
// element up one slot through the RAMs with a read state and then a compare-and-write
// state; the input is ready again only once both stores hold the word. After the last
// word the two sorted lists are merged by a two-pointer sweep, each step a read state
// and a compare state, and one result word gives the peak count of open intervals plus
// flags for an end below its start and for intervals dropped because the store (256
// entries) was full. One shared magnitude comparator does the compares of the bad-end
// check, the insertion and the sweep. The input is not ready while a word is being
// inserted or a set is swept; a finished result may wait at the output while the next
// set loads.
module max_interval_overlap
    import maxi_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // begin_time [15:0], finish_time [31:16]
    input  logic                   s_axis_tlast,   // last_item
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // peak_rooms [8:0], zero fill above
    output logic [OUT_TUSER_W-1:0] m_axis_tuser    // bad_interval [0], set_overflow [1]
);

    t_state r_state, n_state;

    logic [CNT_W-1:0]     r_count, n_count;
    logic [CNT_W-1:0]     r_idx, n_idx;
    logic [CNT_W-1:0]     r_i, n_i;
    logic [CNT_W-1:0]     r_j, n_j;
    logic [CNT_W-1:0]     r_open, n_open;
    logic [CNT_W-1:0]     r_best, n_best;
    logic                 r_sel, n_sel;
    logic                 r_last, n_last;
    logic                 r_bad, n_bad;
    logic                 r_ovf, n_ovf;
    logic                 r_out_valid, n_out_valid;
    logic [TIME_BITS-1:0] r_beg, n_beg;
    logic [TIME_BITS-1:0] r_fin, n_fin;
    logic [PEAK_W-1:0]    r_out_peak, n_out_peak;
    logic                 r_out_bad, n_out_bad;
    logic                 r_out_ovf, n_out_ovf;

    logic                 in_acc;
    logic                 has_room;
    logic                 idx_zero;
    logic                 i_done;
    logic                 j_done;
    logic                 out_free;
    logic                 ins_stop;
    logic [TIME_BITS-1:0] ins_v;
    logic [TIME_BITS-1:0] rd_cur;
    logic [CMP_W-1:0]     cmp_a;
    logic [CMP_W-1:0]     cmp_b;
    logic                 cmp_lt;
    logic [PEAK_W-1:0]    peak_sat;

    logic                 s_we;
    logic                 e_we;
    logic [IDX_W-1:0]     waddr;
    logic [TIME_BITS-1:0] wdata;
    logic [IDX_W-1:0]     s_raddr;
    logic [IDX_W-1:0]     e_raddr;
    logic [TIME_BITS-1:0] s_rdata;
    logic [TIME_BITS-1:0] e_rdata;

    // Sorted start-time and end-time stores.
    maxi_ram #(
        .WIDTH (TIME_BITS),
        .DEPTH (MAX_INTERVALS)
    ) u_start_ram (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (s_raddr),
        .o_rdata (s_rdata)
    );

    maxi_ram #(
        .WIDTH (TIME_BITS),
        .DEPTH (MAX_INTERVALS)
    ) u_end_ram (
        .i_clk   (i_clk),
        .i_we    (e_we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (e_raddr),
        .o_rdata (e_rdata)
    );

    // Handshake and status terms.
    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign has_room      = (r_count != CNT_W'(MAX_INTERVALS));
    assign idx_zero      = (r_idx == '0);
    assign i_done        = (r_i == r_count);
    assign j_done        = (r_j == r_count);
    assign out_free      = !r_out_valid || m_axis_tready;
    assign ins_v         = r_sel ? r_fin : r_beg;
    assign rd_cur        = r_sel ? e_rdata : s_rdata;
    assign ins_stop      = ((r_state == ST_INS_CHK) && idx_zero) ||
                           ((r_state == ST_INS_CMP) && !cmp_lt);
    assign peak_sat      = (32'(r_best) > 32'(PEAK_MAX)) ? PEAK_W'(PEAK_MAX)
                                                         : PEAK_W'(r_best);

    // Shared comparator: operand selection by sequencer state.
    always_comb begin
        cmp_a = '0;
        cmp_b = '0;
        unique case (r_state)
            ST_BAD: begin
                cmp_a = CMP_W'(r_fin);
                cmp_b = CMP_W'(r_beg);
            end
            ST_INS_CMP: begin
                cmp_a = CMP_W'(ins_v);
                cmp_b = CMP_W'(rd_cur);
            end
            ST_SW_RD: begin
                cmp_a = CMP_W'(r_best);
                cmp_b = CMP_W'(r_open);
            end
            ST_SW_CMP: begin
                cmp_a = CMP_W'(s_rdata);
                cmp_b = CMP_W'(e_rdata);
            end
            default: begin
                cmp_a = '0;
                cmp_b = '0;
            end
        endcase
    end

    assign cmp_lt = (cmp_a < cmp_b);

    // Next-state logic of the sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (has_room) begin
                        n_state = ST_BAD;
                    end else if (s_axis_tlast) begin
                        n_state = ST_SW_INIT;
                    end
                end
            end
            ST_BAD: begin
                n_state = ST_INS_CHK;
            end
            ST_INS_CHK, ST_INS_CMP: begin
                if (ins_stop) begin
                    if (!r_sel) begin
                        n_state = ST_INS_CHK;
                    end else if (r_last) begin
                        n_state = ST_SW_INIT;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end else begin
                    n_state = (r_state == ST_INS_CHK) ? ST_INS_CMP : ST_INS_CHK;
                end
            end
            ST_SW_INIT: begin
                n_state = ST_SW_RD;
            end
            ST_SW_RD: begin
                n_state = i_done ? ST_SW_DONE : ST_SW_CMP;
            end
            ST_SW_CMP: begin
                n_state = ST_SW_RD;
            end
            ST_SW_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Datapath and memory controls of the sequencer.
    always_comb begin
        n_count     = r_count;
        n_idx       = r_idx;
        n_i         = r_i;
        n_j         = r_j;
        n_open      = r_open;
        n_best      = r_best;
        n_sel       = r_sel;
        n_last      = r_last;
        n_bad       = r_bad;
        n_ovf       = r_ovf;
        n_beg       = r_beg;
        n_fin       = r_fin;
        n_out_peak  = r_out_peak;
        n_out_bad   = r_out_bad;
        n_out_ovf   = r_out_ovf;
        n_out_valid = r_out_valid && !m_axis_tready;
        s_we        = 1'b0;
        e_we        = 1'b0;
        waddr       = r_idx[IDX_W-1:0];
        wdata       = ins_v;
        s_raddr     = r_i[IDX_W-1:0];
        e_raddr     = r_j[IDX_W-1:0];
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (has_room) begin
                        n_beg  = TIME_BITS'(s_axis_tdata[TIME_IN_W-1:0]);
                        n_fin  = TIME_BITS'(s_axis_tdata[IN_TDATA_W-1:TIME_IN_W]);
                        n_last = s_axis_tlast;
                        n_sel  = 1'b0;
                        n_idx  = r_count;
                    end else begin
                        n_ovf = 1'b1;
                    end
                end
            end
            ST_BAD: begin
                if (cmp_lt) begin
                    n_bad = 1'b1;
                end
            end
            ST_INS_CHK, ST_INS_CMP: begin
                // Shift one larger element up, or drop the new value into its slot.
                if (r_state == ST_INS_CHK && !idx_zero) begin
                    s_raddr = IDX_W'(r_idx - CNT_W'(1));
                    e_raddr = IDX_W'(r_idx - CNT_W'(1));
                end else begin
                    s_we = !r_sel;
                    e_we = r_sel;
                    if (!ins_stop) begin
                        wdata = rd_cur;
                        n_idx = r_idx - CNT_W'(1);
                    end
                end
                if (ins_stop) begin
                    if (!r_sel) begin
                        n_sel = 1'b1;
                        n_idx = r_count;
                    end else begin
                        n_count = r_count + CNT_W'(1);
                    end
                end
            end
            ST_SW_INIT: begin
                n_i    = '0;
                n_j    = '0;
                n_open = '0;
                n_best = '0;
            end
            ST_SW_RD: begin
                // Fold the previous step's open count into the peak.
                if (cmp_lt) begin
                    n_best = r_open;
                end
            end
            ST_SW_CMP: begin
                if (j_done || cmp_lt) begin
                    n_open = r_open + CNT_W'(1);
                    n_i    = r_i + CNT_W'(1);
                end else begin
                    if (r_open != '0) begin
                        n_open = r_open - CNT_W'(1);
                    end
                    n_j = r_j + CNT_W'(1);
                end
            end
            ST_SW_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_peak  = peak_sat;
                    n_out_bad   = r_bad;
                    n_out_ovf   = r_ovf;
                    n_count     = '0;
                    n_bad       = 1'b0;
                    n_ovf       = 1'b0;
                end
            end
            default: begin
                n_out_valid = r_out_valid && !m_axis_tready;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_open      <= '0;
            r_best      <= '0;
            r_bad       <= 1'b0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_open      <= n_open;
            r_best      <= n_best;
            r_bad       <= n_bad;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload and pointer registers.
    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_i        <= n_i;
        r_j        <= n_j;
        r_sel      <= n_sel;
        r_last     <= n_last;
        r_beg      <= n_beg;
        r_fin      <= n_fin;
        r_out_peak <= n_out_peak;
        r_out_bad  <= n_out_bad;
        r_out_ovf  <= n_out_ovf;
    end

    // Result word.
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(OUT_TDATA_W - PEAK_W)'(0), r_out_peak};
    assign m_axis_tuser  = {r_out_ovf, r_out_bad};

endmodule

@@ rtl/maxi_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Used for the start-time and end-time stores; depends on nothing.
module maxi_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

@@ rtl/maxi_chk.sv @@
// Port-level checker for the peak interval overlap block, and its bind to the top level.
// Depends on maxi_pkg for the port widths.
module maxi_chk
    import maxi_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input logic                   s_axis_tlast,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [OUT_TUSER_W-1:0] m_axis_tuser
);

    // A stalled result word holds its valid and its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result word changed while stalled");

    // The last word of a set starts insertion or the sweep, so the input closes.
    a_last_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("input still ready after the last word of a set");

    // A new result only appears at the end of a sweep, while the input is closed.
    a_result_after_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result appeared without a sweep");

    // The fill bits above the peak count stay zero.
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[OUT_TDATA_W-1:PEAK_W] == '0))
        else $error("nonzero fill bits in result word");

endmodule

bind max_interval_overlap maxi_chk u_maxi_chk (.*);
